FILE: rtl/dehf_pkg.sv
// Shared types and constants for the deduplicating endpoint hint queue.
// Used by the controller, the datapath, the top level and the testbench.
package dehf_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int ADDR_W    = 64;
  localparam int PORT_W    = 16;
  localparam int ENTRY_W   = 2 * ADDR_W + PORT_W;
  localparam int COUNT_W   = 5;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_POPPED    = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  typedef struct packed {
    logic       load;
    logic       scan;
    logic       rd_pop;
    logic       pop_take;
    logic       push_write;
    logic       set_status;
    logic [2:0] status;
    logic       out_load;
  } dehf_cmd_t;

  typedef struct packed {
    logic is_push;
    logic invalid;
    logic empty;
    logic full;
    logic scan_done;
    logic match;
    logic out_busy;
  } dehf_sts_t;

endpackage

FILE: rtl/dedup_endpoint_hint_fifo_unit.sv
// Top level of the deduplicating endpoint hint queue.
// Depends on dehf_pkg, dehf_ctrl, dehf_dp and dehf_ram.

// Bounded FIFO of endpoints (128-bit address, 16-bit port) that refuses
// duplicates. Each accepted beat yields exactly one result beat. A push
// with a clear addr_valid or a zero port is refused at once; otherwise the
// queued entries are read from the entry RAM one per cycle and compared
// against the new endpoint, so a push's scan runs over every queued entry
// through that single RAM read port. One item is in work at a time; the
// next beat is taken as soon as the result sits in the output register,
// even while the consumer stalls it. No clearing pass is needed after
// reset.
module dedup_endpoint_hint_fifo_unit
  import dehf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [ADDR_W-1:0]  in_addr_hi,
  input  logic [ADDR_W-1:0]  in_addr_lo,
  input  logic [PORT_W-1:0]  in_port,
  input  logic               in_addr_valid,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [ADDR_W-1:0]  out_addr_hi,
  output logic [ADDR_W-1:0]  out_addr_lo,
  output logic [PORT_W-1:0]  out_port,
  output logic               out_pending,
  output logic [COUNT_W-1:0] out_count
);

  dehf_cmd_t cmd;
  dehf_sts_t sts;

  dehf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dehf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_op         (in_op),
    .in_addr_hi    (in_addr_hi),
    .in_addr_lo    (in_addr_lo),
    .in_port       (in_port),
    .in_addr_valid (in_addr_valid),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_addr_hi   (out_addr_hi),
    .out_addr_lo   (out_addr_lo),
    .out_port      (out_port),
    .out_pending   (out_pending),
    .out_count     (out_count),
    .cmd           (cmd),
    .sts           (sts)
  );

  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall
  ) else $error("input taken again right after a beat was accepted");

  a_no_write_when_full: assert property (
    @(posedge clk) disable iff (!rst_n)
    cmd.push_write |-> (!sts.full && !sts.match && sts.is_push)
  ) else $error("entry written on a full queue or a duplicate");

  a_payload_zero: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_POPPED)) |->
      (out_addr_hi == '0 && out_addr_lo == '0 && out_port == '0)
  ) else $error("endpoint payload nonzero on a result that is not a pop");

  a_load_only_when_free: assert property (
    @(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && out_stall)
  ) else $error("result register overwritten while stalled");

endmodule

FILE: rtl/dehf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the queued endpoints.
module dehf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/dehf_ctrl.sv
// Sequencing state machine of the endpoint hint queue.
// Depends on dehf_pkg; drives the datapath by commands, reads its status.
module dehf_ctrl
  import dehf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dehf_sts_t  sts,
  output dehf_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_POP   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.is_push) begin
          if (sts.invalid) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_INVALID;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end else if (sts.empty) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_EMPTY;
          state_nxt      = S_DONE;
        end else begin
          cmd.rd_pop = 1'b1;
          state_nxt  = S_POP;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          cmd.set_status = 1'b1;
          state_nxt      = S_DONE;
          if (sts.match) begin
            cmd.status = ST_DUPLICATE;
          end else if (sts.full) begin
            cmd.status = ST_FULL;
          end else begin
            cmd.status     = ST_ADDED;
            cmd.push_write = 1'b1;
          end
        end
      end
      S_POP: begin
        cmd.pop_take   = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status     = ST_POPPED;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

FILE: rtl/dehf_dp.sv
// Datapath of the endpoint hint queue: circular entry store, pointers,
// duplicate compare pipeline and result registers. Depends on dehf_pkg
// and dehf_ram.
module dehf_dp
  import dehf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_op,
  input  logic [ADDR_W-1:0]  in_addr_hi,
  input  logic [ADDR_W-1:0]  in_addr_lo,
  input  logic [PORT_W-1:0]  in_port,
  input  logic               in_addr_valid,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [ADDR_W-1:0]  out_addr_hi,
  output logic [ADDR_W-1:0]  out_addr_lo,
  output logic [PORT_W-1:0]  out_port,
  output logic               out_pending,
  output logic [COUNT_W-1:0] out_count,
  input  dehf_cmd_t          cmd,
  output dehf_sts_t          sts
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW:0]   DEPTH_W  = (CW + 1)'(DEPTH);

  logic [AW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      rp_r, rp_nxt;
  logic [CW-1:0]      remain_r, remain_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic               match_r, match_nxt;
  logic               op_r;
  logic               addr_valid_r;
  logic [ENTRY_W-1:0] key_r;
  logic [2:0]         res_status_r;
  logic [ENTRY_W-1:0] res_data_r;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_status_r;
  logic [ENTRY_W-1:0] out_data_r;
  logic [CW-1:0]      out_cnt_r;

  logic               scan_issue;
  logic               rd_en;
  logic [ENTRY_W-1:0] rd_data;
  logic               hit;
  logic [CW:0]        tail_sum;
  logic [CW:0]        tail_wrap;
  logic [AW-1:0]      tail;
  logic [CW+COUNT_W-1:0] cnt_ext;

  dehf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push_write),
    .waddr (tail),
    .wdata (key_r),
    .re    (rd_en),
    .raddr (rp_r),
    .rdata (rd_data)
  );

  assign tail_sum  = (CW + 1)'(head_r) + {1'b0, count_r};
  assign tail_wrap = (tail_sum >= DEPTH_W) ? (tail_sum - DEPTH_W) : tail_sum;
  assign tail      = tail_wrap[AW-1:0];

  assign scan_issue = cmd.scan && (remain_r != '0);
  assign rd_en      = scan_issue || cmd.rd_pop;
  assign hit        = cmp_vld_r && (rd_data == key_r);

  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    rp_nxt      = rp_r;
    remain_nxt  = remain_r;
    cmp_vld_nxt = 1'b0;
    match_nxt   = match_r || hit;
    if (cmd.load) begin
      rp_nxt     = head_r;
      remain_nxt = count_r;
      match_nxt  = 1'b0;
    end
    if (scan_issue) begin
      rp_nxt      = (rp_r == LAST_IDX) ? '0 : rp_r + 1'b1;
      remain_nxt  = remain_r - 1'b1;
      cmp_vld_nxt = 1'b1;
    end
    if (cmd.push_write) begin
      count_nxt = count_r + 1'b1;
    end
    if (cmd.pop_take) begin
      head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      rp_r        <= '0;
      remain_r    <= '0;
      cmp_vld_r   <= 1'b0;
      match_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      rp_r        <= rp_nxt;
      remain_r    <= remain_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      match_r     <= match_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r         <= in_op;
      addr_valid_r <= in_addr_valid;
      key_r        <= {in_addr_hi, in_addr_lo, in_port};
      res_data_r   <= '0;
    end
    if (cmd.pop_take) begin
      res_data_r <= rd_data;
    end
    if (cmd.set_status) begin
      res_status_r <= cmd.status;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_data_r   <= res_data_r;
      out_cnt_r    <= count_r;
    end
  end

  assign sts.is_push   = (op_r == OP_PUSH);
  assign sts.invalid   = !addr_valid_r || (key_r[PORT_W-1:0] == '0);
  assign sts.empty     = (count_r == '0);
  assign sts.full      = (count_r == FULL_CNT);
  assign sts.scan_done = (remain_r == '0) && !cmp_vld_r;
  assign sts.match     = match_r;
  assign sts.out_busy  = out_valid_r && out_stall;

  assign cnt_ext     = {{COUNT_W{1'b0}}, out_cnt_r};
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_addr_hi = out_data_r[ENTRY_W-1 -: ADDR_W];
  assign out_addr_lo = out_data_r[PORT_W +: ADDR_W];
  assign out_port    = out_data_r[PORT_W-1:0];
  assign out_pending = (out_cnt_r != '0);
  assign out_count   = cnt_ext[COUNT_W-1:0];

endmodule

FILE: tb/sv/tb_dedup_endpoint_hint_fifo_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for dedup_endpoint_hint_fifo_unit: a directed table, then random
// push/pop traffic, checked against table values where given, else a behavioral queue model
// held here. Depends on dehf_pkg and the dedup_endpoint_hint_fifo_unit RTL.
module tb_dedup_endpoint_hint_fifo_unit;
  import dehf_pkg::*;

  localparam int QDEPTH = DEPTH_DEF;
  localparam int POOL_N = 24;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo;
    logic [PORT_W-1:0] port;
    logic              addr_valid;
  } beat_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [ADDR_W-1:0]  hi;
    logic [ADDR_W-1:0]  lo;
    logic [PORT_W-1:0]  port;
    logic               pending;
    logic [COUNT_W-1:0] count;
  } result_t;

  typedef struct {
    beat_t   b;
    int      reps;
    logic    typed;
    result_t want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = OP_PUSH;
  logic [ADDR_W-1:0] in_addr_hi = '0;
  logic [ADDR_W-1:0] in_addr_lo = '0;
  logic [PORT_W-1:0] in_port = '0;
  logic in_addr_valid = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic [ADDR_W-1:0] out_addr_hi;
  logic [ADDR_W-1:0] out_addr_lo;
  logic [PORT_W-1:0] out_port;
  logic out_pending;
  logic [COUNT_W-1:0] out_count;

  logic [ADDR_W-1:0] ep_hi [QDEPTH];
  logic [ADDR_W-1:0] ep_lo [QDEPTH];
  logic [PORT_W-1:0] ep_port [QDEPTH];
  int ep_count = 0;

  result_t pending_results [$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  dedup_endpoint_hint_fifo_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_addr_hi(in_addr_hi),
    .in_addr_lo(in_addr_lo),
    .in_port(in_port),
    .in_addr_valid(in_addr_valid),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_addr_hi(out_addr_hi),
    .out_addr_lo(out_addr_lo),
    .out_port(out_port),
    .out_pending(out_pending),
    .out_count(out_count)
  );

  always #2 clk = ~clk;

  function automatic result_t res(logic [2:0] st, logic [ADDR_W-1:0] hi,
                                  logic [ADDR_W-1:0] lo, logic [PORT_W-1:0] port,
                                  logic pend, int cnt);
    result_t r;
    r.status = st;
    r.hi = hi;
    r.lo = lo;
    r.port = port;
    r.pending = pend;
    r.count = COUNT_W'(cnt);
    return r;
  endfunction

  function automatic step_row_t step_row(logic op, logic [ADDR_W-1:0] hi,
                                         logic [ADDR_W-1:0] lo, logic [PORT_W-1:0] port,
                                         logic av, int reps, logic typed, result_t want);
    step_row_t s;
    s.b.op = op;
    s.b.hi = hi;
    s.b.lo = lo;
    s.b.port = port;
    s.b.addr_valid = av;
    s.reps = reps;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  task automatic fifo_predict(input beat_t b, output result_t r);
    int i;
    logic hit;
    r = '0;
    hit = 1'b0;
    if (b.op == OP_PUSH) begin
      for (i = 0; i < ep_count; i++) begin
        if (ep_hi[i] == b.hi && ep_lo[i] == b.lo && ep_port[i] == b.port) hit = 1'b1;
      end
      if (!b.addr_valid || b.port == '0) begin
        r.status = ST_INVALID;
      end else if (hit) begin
        r.status = ST_DUPLICATE;
      end else if (ep_count >= QDEPTH) begin
        r.status = ST_FULL;
      end else begin
        ep_hi[ep_count] = b.hi;
        ep_lo[ep_count] = b.lo;
        ep_port[ep_count] = b.port;
        ep_count++;
        r.status = ST_ADDED;
      end
    end else if (ep_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status = ST_POPPED;
      r.hi = ep_hi[0];
      r.lo = ep_lo[0];
      r.port = ep_port[0];
      for (i = 0; i < ep_count - 1; i++) begin
        ep_hi[i] = ep_hi[i + 1];
        ep_lo[i] = ep_lo[i + 1];
        ep_port[i] = ep_port[i + 1];
      end
      ep_count--;
    end
    r.pending = (ep_count != 0);
    r.count = COUNT_W'(ep_count);
  endtask

  // The beat is accepted at the first edge that sees in_stall low after in_valid rose.
  task automatic send_beat(input beat_t b, output result_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= b.op;
    in_addr_hi <= b.hi;
    in_addr_lo <= b.lo;
    in_port <= b.port;
    in_addr_valid <= b.addr_valid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fifo_predict(b, r);
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = res(out_status, out_addr_hi, out_addr_lo, out_port, out_pending, out_count);
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: result beat with nothing expected: %h", $time, got);
          end
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.hi !== want.hi || got.lo !== want.lo ||
              got.port !== want.port || got.pending !== want.pending ||
              got.count !== want.count) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("%0t: expected st=%0d hi=%h lo=%h port=%h pend=%b cnt=%0d",
                       $time, want.status, want.hi, want.lo, want.port, want.pending,
                       want.count);
              $display("%0t: actual   st=%0d hi=%h lo=%h port=%h pend=%b cnt=%0d",
                       $time, got.status, got.hi, got.lo, got.port, got.pending,
                       got.count);
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    step_row_t dir_rows [$];
    logic [ADDR_W-1:0] pool_hi [POOL_N];
    logic [ADDR_W-1:0] pool_lo [POOL_N];
    logic [PORT_W-1:0] pool_port [POOL_N];
    int idle_by_phase [4];
    int stall_by_phase [4];
    int ph;
    int n;
    int k;
    int idx;
    int pick;
    int pop_pct;
    beat_t b;
    result_t r;

    idle_by_phase = '{0, 49, 0, 6};
    stall_by_phase = '{0, 0, 49, 6};

    dir_rows.push_back(step_row(OP_POP, '0, '0, '0, 1'b0, 1, 1'b1,
                                res(ST_EMPTY, '0, '0, '0, 1'b0, 0)));
    dir_rows.push_back(step_row(OP_PUSH, '1, '1, '1, 1'b0, 1, 1'b1,
                                res(ST_INVALID, '0, '0, '0, 1'b0, 0)));
    dir_rows.push_back(step_row(OP_PUSH, '1, '1, '0, 1'b1, 1, 1'b1,
                                res(ST_INVALID, '0, '0, '0, 1'b0, 0)));
    dir_rows.push_back(step_row(OP_PUSH, '1, '1, '1, 1'b1, 1, 1'b1,
                                res(ST_ADDED, '0, '0, '0, 1'b1, 1)));
    dir_rows.push_back(step_row(OP_PUSH, '0, '0, 16'd1, 1'b1, 1, 1'b1,
                                res(ST_ADDED, '0, '0, '0, 1'b1, 2)));
    dir_rows.push_back(step_row(OP_PUSH, '1, '1, '1, 1'b1, 1, 1'b1,
                                res(ST_DUPLICATE, '0, '0, '0, 1'b1, 2)));
    dir_rows.push_back(step_row(OP_PUSH, '1, '1, 16'hFFFE, 1'b1, 1, 1'b0, '0));
    dir_rows.push_back(step_row(OP_POP, '0, '0, '0, 1'b0, 1, 1'b1,
                                res(ST_POPPED, '1, '1, '1, 1'b1, 2)));
    dir_rows.push_back(step_row(OP_PUSH, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A00,
                                16'h8000, 1'b1, 14, 1'b0, '0));
    dir_rows.push_back(step_row(OP_PUSH, 64'd1, 64'd2, 16'd3, 1'b1, 1, 1'b1,
                                res(ST_FULL, '0, '0, '0, 1'b1, QDEPTH)));
    dir_rows.push_back(step_row(OP_PUSH, '0, '0, 16'd1, 1'b1, 1, 1'b1,
                                res(ST_DUPLICATE, '0, '0, '0, 1'b1, QDEPTH)));
    dir_rows.push_back(step_row(OP_PUSH, 64'd1, 64'd2, 16'd3, 1'b0, 1, 1'b1,
                                res(ST_INVALID, '0, '0, '0, 1'b1, QDEPTH)));
    dir_rows.push_back(step_row(OP_POP, '1, '1, '1, 1'b1, QDEPTH, 1'b0, '0));
    dir_rows.push_back(step_row(OP_POP, '0, '0, '0, 1'b0, 1, 1'b1,
                                res(ST_EMPTY, '0, '0, '0, 1'b0, 0)));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      for (k = 0; k < dir_rows[i].reps; k++) begin
        b = dir_rows[i].b;
        b.lo = b.lo + ADDR_W'(k);
        send_beat(b, r);
        pending_results.push_back(dir_rows[i].typed ? dir_rows[i].want : r);
      end
    end

    // A small pool of endpoints makes duplicates and a full queue common; odd entries
    // share the address of their neighbor with a different port.
    for (k = 0; k < POOL_N; k++) begin
      if (k % 2 == 1) begin
        pool_hi[k] = pool_hi[k - 1];
        pool_lo[k] = pool_lo[k - 1];
      end else begin
        pool_hi[k] = {$urandom, $urandom};
        pool_lo[k] = {$urandom, $urandom};
      end
      pool_port[k] = PORT_W'($urandom_range(65535, 1));
    end

    for (ph = 0; ph < 4; ph++) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (pending_results.size() != 0);
      send_idle_pct = idle_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      pop_pct = 45;
      for (n = 0; n < 100; n++) begin
        if (n % 20 == 0) begin
          case ($urandom_range(2))
            0: pop_pct = 15;
            1: pop_pct = 45;
            default: pop_pct = 75;
          endcase
        end
        b.op = ($urandom_range(99) < pop_pct) ? OP_POP : OP_PUSH;
        b.hi = {$urandom, $urandom};
        b.lo = {$urandom, $urandom};
        b.port = PORT_W'($urandom);
        b.addr_valid = 1'b1;
        idx = $urandom_range(POOL_N - 1);
        pick = $urandom_range(99);
        if (pick < 55) begin
          b.hi = pool_hi[idx];
          b.lo = pool_lo[idx];
          b.port = pool_port[idx];
        end else if (pick < 63) begin
          b.addr_valid = 1'b0;
        end else if (pick < 70) begin
          b.port = '0;
        end else if (pick < 78) begin
          b.hi = pool_hi[idx];
          b.lo = pool_lo[idx] ^ (64'd1 << $urandom_range(ADDR_W - 1));
          b.port = pool_port[idx];
        end
        send_beat(b, r);
        pending_results.push_back(r);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (2 * QDEPTH + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_dedup_endpoint_hint_fifo_unit passed");
    end else begin
      $display("tb_dedup_endpoint_hint_fifo_unit failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_dedup_endpoint_hint_fifo_unit failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/dehf_pkg.sv
rtl/dehf_ram.sv
rtl/dehf_ctrl.sv
rtl/dehf_dp.sv
rtl/dedup_endpoint_hint_fifo_unit.sv
tb/sv/tb_dedup_endpoint_hint_fifo_unit.sv
